[hdl/esmb_pkg.sv]
// Shared types, constants and helper functions for the Euler scale-rotate-translate
// matrix builder. Every module of the block imports this package; it depends on nothing.
package esmb_pkg;

   // Default and upper limit for the CORDIC step count.
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int CORDIC_STEPS_MAX = 32;

   // Depth of the queue between the angle front end and the matrix back end.
   localparam int QUEUE_DEPTH = 4;

   // Width of the CORDIC datapath (Q2.30 with headroom).
   localparam int CORDIC_W = 34;

   // Angle reduction: bias the angle by a whole number of turns so that it is never negative.
   localparam logic [32:0] DEG_BIAS    = 33'd2170552320;
   localparam logic [16:0] RECIP_360   = 17'd93207;
   localparam int          RECIP_SHIFT = 25;
   localparam logic [16:0] DEG_360     = 17'd360;
   localparam logic [24:0] DEG_90      = 25'd5898240;
   localparam logic [24:0] DEG_180     = 25'd11796480;
   localparam logic [24:0] DEG_270     = 25'd17694720;
   localparam logic [24:0] DEG_FULL    = 25'd23592960;

   // Degrees to radians as a Q0.32 factor.
   localparam logic [26:0] RAD_PER_DEG = 27'd74961321;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [CORDIC_W-1:0] ONE_Q30     = 34'sd1073741824;

   typedef logic signed [31:0] q16_type;
   typedef logic [22:0]        fold_angle_type;

   typedef struct packed {
      q16_type scale_x;
      q16_type scale_y;
      q16_type scale_z;
      q16_type angle_x;
      q16_type angle_y;
      q16_type angle_z;
      q16_type shift_x;
      q16_type shift_y;
      q16_type shift_z;
   } req_type;

   typedef struct packed {
      q16_type row0_a;
      q16_type row0_b;
      q16_type row0_c;
      q16_type row1_a;
      q16_type row1_b;
      q16_type row1_c;
      q16_type row2_a;
      q16_type row2_b;
      q16_type row2_c;
      q16_type offset_x;
      q16_type offset_y;
      q16_type offset_z;
   } rsp_type;

   // Data that travels alongside the angles to the back end.
   typedef struct packed {
      logic [2:0]          neg_s;
      logic [2:0]          neg_c;
      logic [2:0][31:0]    scale;
      logic [2:0][31:0]    shift;
   } side_type;

   // One queue word: folded angles in [0, 90] degrees plus the side data.
   typedef struct packed {
      fold_angle_type [2:0] angle;
      side_type             side;
   } fold_type;

   // Arctangent of 2^-idx in Q2.30, rounded down.
   function automatic logic signed [CORDIC_W-1:0] atan_q30(input int idx);
      logic signed [CORDIC_W-1:0] v;
      case (idx)
         0:  v = 34'sd843314856;
         1:  v = 34'sd497837829;
         2:  v = 34'sd263043836;
         3:  v = 34'sd133525158;
         4:  v = 34'sd67021686;
         5:  v = 34'sd33543515;
         6:  v = 34'sd16775850;
         7:  v = 34'sd8388437;
         8:  v = 34'sd4194282;
         9:  v = 34'sd2097149;
         10: v = 34'sd1048575;
         11: v = 34'sd524287;
         12: v = 34'sd262143;
         13: v = 34'sd131071;
         14: v = 34'sd65535;
         15: v = 34'sd32767;
         16: v = 34'sd16383;
         17: v = 34'sd8191;
         18: v = 34'sd4095;
         19: v = 34'sd2047;
         20: v = 34'sd1023;
         21: v = 34'sd511;
         22: v = 34'sd255;
         23: v = 34'sd127;
         24: v = 34'sd63;
         25: v = 34'sd31;
         26: v = 34'sd15;
         27: v = 34'sd7;
         28: v = 34'sd3;
         29: v = 34'sd1;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Q2.30 product rounded half up; operands stay within plus or minus one.
   function automatic logic signed [31:0] mul_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b + 64'sd536870912;
      return p[61:30];
   endfunction

endpackage

[hdl/esmb_front.sv]
// Front end: accepts request words, reduces each angle modulo 360 degrees and
// folds it into [0, 90] degrees with sign flags. Depends on esmb_pkg.
module esmb_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  esmb_pkg::req_type  req_data,
   output logic               push_valid,
   input  logic               push_ready,
   output esmb_pkg::fold_type push_data
);
   import esmb_pkg::*;

   logic             adv;
   logic             s1_vld_ff, s2_vld_ff;
   logic [31:0]      deg [3];
   logic [16:0]      s1_h_in [3],  s1_h_ff [3];
   logic [15:0]      s1_lo_in [3], s1_lo_ff [3];
   logic [7:0]       s1_q_in [3],  s1_q_ff [3];
   side_type         s1_side_in, s1_side_ff;
   fold_type         s2_in, s2_ff;

   // The whole front moves together unless its last word cannot enter the queue.
   assign adv        = !s2_vld_ff || push_ready;
   assign req_ready  = adv;
   assign push_valid = s2_vld_ff;
   assign push_data  = s2_ff;

   assign deg[0] = req_data.angle_x;
   assign deg[1] = req_data.angle_y;
   assign deg[2] = req_data.angle_z;

   // Stage one: bias the angle, split off the fraction and estimate whole turns of 360.
   always_comb begin
      logic [32:0] u;
      logic [33:0] prod;
      for (int a = 0; a < 3; a++) begin
         u           = {deg[a][31], deg[a]} + DEG_BIAS;
         s1_h_in[a]  = u[32:16];
         s1_lo_in[a] = u[15:0];
         prod        = 34'(s1_h_in[a]) * 34'(RECIP_360);
         s1_q_in[a]  = prod[RECIP_SHIFT+7:RECIP_SHIFT];
      end
      s1_side_in.neg_s    = '0;
      s1_side_in.neg_c    = '0;
      s1_side_in.scale[0] = req_data.scale_x;
      s1_side_in.scale[1] = req_data.scale_y;
      s1_side_in.scale[2] = req_data.scale_z;
      s1_side_in.shift[0] = req_data.shift_x;
      s1_side_in.shift[1] = req_data.shift_y;
      s1_side_in.shift[2] = req_data.shift_z;
   end

   // Stage two: remainder in degrees, then fold by quadrant.
   always_comb begin
      logic [16:0] qm;
      logic [16:0] rem;
      logic [24:0] r;
      s2_in.side = s1_side_ff;
      for (int a = 0; a < 3; a++) begin
         qm  = 17'(s1_q_ff[a]) * DEG_360;
         rem = s1_h_ff[a] - qm;
         r   = {rem[8:0], s1_lo_ff[a]};
         priority if (r <= DEG_90) begin
            s2_in.angle[a]      = r[22:0];
            s2_in.side.neg_s[a] = 1'b0;
            s2_in.side.neg_c[a] = 1'b0;
         end else if (r <= DEG_180) begin
            s2_in.angle[a]      = 23'(DEG_180 - r);
            s2_in.side.neg_s[a] = 1'b0;
            s2_in.side.neg_c[a] = 1'b1;
         end else if (r <= DEG_270) begin
            s2_in.angle[a]      = 23'(r - DEG_180);
            s2_in.side.neg_s[a] = 1'b1;
            s2_in.side.neg_c[a] = 1'b1;
         end else begin
            s2_in.angle[a]      = 23'(DEG_FULL - r);
            s2_in.side.neg_s[a] = 1'b1;
            s2_in.side.neg_c[a] = 1'b0;
         end
      end
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_h_ff    <= s1_h_in;
         s1_lo_ff   <= s1_lo_in;
         s1_q_ff    <= s1_q_in;
         s1_side_ff <= s1_side_in;
         s2_ff      <= s2_in;
      end
   end

endmodule

[hdl/esmb_queue.sv]
// Short queue of folded-angle words between the front and back ends.
// Depends on esmb_pkg for the word type.
module esmb_queue #(
   parameter int DEPTH = esmb_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  esmb_pkg::fold_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output esmb_pkg::fold_type pop_data
);
   import esmb_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0]   LAST = PW'(DEPTH - 1);
   localparam logic [CNTW-1:0] FULL = CNTW'(DEPTH);

   fold_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            do_push, do_pop;

   assign push_ready = (cnt_ff != FULL);
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/esmb_cordic.sv]
// Pipelined rotation-mode CORDIC: one register stage per iteration, giving
// cosine and sine of a Q2.30 angle. Depends on esmb_pkg.
module esmb_cordic #(
   parameter int STEPS = esmb_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [esmb_pkg::CORDIC_W-1:0] z_in,
   output logic signed [esmb_pkg::CORDIC_W-1:0] x_out,
   output logic signed [esmb_pkg::CORDIC_W-1:0] y_out
);
   import esmb_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff [STEPS];
   logic signed [CORDIC_W-1:0] y_ff [STEPS];
   logic signed [CORDIC_W-1:0] z_ff [STEPS];

   genvar i;
   generate
      for (i = 0; i < STEPS; i++) begin : g_step
         logic signed [CORDIC_W-1:0] x_cur, y_cur, z_cur, x_nxt, y_nxt, z_nxt;

         if (i == 0) begin : g_first
            assign x_cur = CORDIC_GAIN;
            assign y_cur = '0;
            assign z_cur = z_in;
         end else begin : g_next
            assign x_cur = x_ff[i-1];
            assign y_cur = y_ff[i-1];
            assign z_cur = z_ff[i-1];
         end

         // Rotate toward zero residual angle.
         always_comb begin
            if (z_cur >= 0) begin
               x_nxt = x_cur - (y_cur >>> i);
               y_nxt = y_cur + (x_cur >>> i);
               z_nxt = z_cur - atan_q30(i);
            end else begin
               x_nxt = x_cur + (y_cur >>> i);
               y_nxt = y_cur - (x_cur >>> i);
               z_nxt = z_cur + atan_q30(i);
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i] <= x_nxt;
               y_ff[i] <= y_nxt;
               z_ff[i] <= z_nxt;
            end
         end
      end
   endgenerate

   assign x_out = x_ff[STEPS-1];
   assign y_out = y_ff[STEPS-1];

endmodule

[hdl/esmb_back.sv]
// Back end: radians, three CORDIC lanes, Euler matrix products, row scaling,
// rounding and saturation, and the output register. Depends on esmb_pkg, esmb_cordic.
module esmb_back #(
   parameter int STEPS = esmb_pkg::CORDIC_STEPS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  esmb_pkg::fold_type pop_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output esmb_pkg::rsp_type  rsp_data
);
   import esmb_pkg::*;

   localparam int NV = STEPS + 6;

   logic                       adv;
   logic [NV-1:0]              vld_ff, vld_in;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_data_ff, rsp_data_in;

   logic signed [CORDIC_W-1:0] z_b0_in [3], z_b0_ff [3];
   side_type                   side_b0_ff;
   side_type                   side_ln_ff [STEPS];
   logic signed [CORDIC_W-1:0] cx_w [3], sy_w [3];

   logic signed [31:0]         s_p0_in [3], c_p0_in [3], s_p0_ff [3], c_p0_ff [3];
   logic [2:0][31:0]           scale_p0_ff, scale_p1_ff, scale_p2_ff, scale_p3_ff;
   logic [2:0][31:0]           shift_p0_ff, shift_p1_ff, shift_p2_ff, shift_p3_ff, shift_p4_ff;

   // Stage p1 terms.
   logic signed [31:0] cycz_ff, cysz_ff, nsy_ff, sxsy_ff, cxsy_ff, cxsz_ff, cxcz_ff;
   logic signed [31:0] sxcy_ff, sxsz_ff, sxcz_ff, cxcy_ff, cz_ff, sz_ff;
   // Stage p2 terms.
   logic signed [31:0] m0_p2_ff, m1_p2_ff, m2_p2_ff, m5_p2_ff, m8_p2_ff;
   logic signed [31:0] ta_ff, tb_ff, tc_ff, td_ff, cxsz2_ff, cxcz2_ff, sxsz2_ff, sxcz2_ff;
   // Stage p3 entries and p4 products.
   logic signed [32:0] m_in [9], m_ff [9];
   logic signed [64:0] prod_in [9], prod_ff [9];
   logic signed [31:0] ent [9];

   // Every stage moves together when the output slot is free or being emptied.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign pop_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign vld_in    = {vld_ff[NV-2:0], pop_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[NV-1];
      end
   end

   // Folded degrees to Q2.30 radians, rounded half up.
   always_comb begin
      logic [49:0] zp;
      for (int a = 0; a < 3; a++) begin
         zp        = 50'(pop_data.angle[a]) * 50'(RAD_PER_DEG) + 50'd131072;
         z_b0_in[a] = {2'b00, zp[49:18]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         z_b0_ff    <= z_b0_in;
         side_b0_ff <= pop_data.side;
         side_ln_ff[0] <= side_b0_ff;
         for (int k = 1; k < STEPS; k++) begin
            side_ln_ff[k] <= side_ln_ff[k-1];
         end
      end
   end

   // One CORDIC lane per axis.
   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_lane
         esmb_cordic #(.STEPS(STEPS)) u_cordic (
            .clock (clock),
            .en    (adv),
            .z_in  (z_b0_ff[g]),
            .x_out (cx_w[g]),
            .y_out (sy_w[g])
         );
      end
   endgenerate

   // Clamp to plus or minus one and apply the quadrant signs.
   always_comb begin
      logic signed [CORDIC_W-1:0] xc, yc;
      for (int a = 0; a < 3; a++) begin
         xc = (cx_w[a] > ONE_Q30) ? ONE_Q30 : ((cx_w[a] < -ONE_Q30) ? -ONE_Q30 : cx_w[a]);
         yc = (sy_w[a] > ONE_Q30) ? ONE_Q30 : ((sy_w[a] < -ONE_Q30) ? -ONE_Q30 : sy_w[a]);
         if (side_ln_ff[STEPS-1].neg_c[a]) xc = -xc;
         if (side_ln_ff[STEPS-1].neg_s[a]) yc = -yc;
         c_p0_in[a] = xc[31:0];
         s_p0_in[a] = yc[31:0];
      end
   end

   // Matrix entries from sines and cosines, then scaling.
   always_comb begin
      m_in[0] = 33'(m0_p2_ff);
      m_in[1] = 33'(m1_p2_ff);
      m_in[2] = 33'(m2_p2_ff);
      m_in[3] = 33'(ta_ff) - 33'(cxsz2_ff);
      m_in[4] = 33'(tb_ff) + 33'(cxcz2_ff);
      m_in[5] = 33'(m5_p2_ff);
      m_in[6] = 33'(tc_ff) + 33'(sxsz2_ff);
      m_in[7] = 33'(td_ff) - 33'(sxcz2_ff);
      m_in[8] = 33'(m8_p2_ff);
      for (int k = 0; k < 9; k++) begin
         prod_in[k] = 65'(m_ff[k]) * 65'($signed(scale_p3_ff[k/3]));
      end
   end

   // Round to Q16.16 and saturate.
   always_comb begin
      logic signed [64:0] rnd;
      logic signed [64:0] sh;
      for (int k = 0; k < 9; k++) begin
         rnd = prod_ff[k] + 65'sd536870912;
         sh  = rnd >>> 30;
         if (sh > 65'sd2147483647) begin
            ent[k] = 32'sh7fffffff;
         end else if (sh < -65'sd2147483648) begin
            ent[k] = 32'sh80000000;
         end else begin
            ent[k] = sh[31:0];
         end
      end
      rsp_data_in.row0_a   = ent[0];
      rsp_data_in.row0_b   = ent[1];
      rsp_data_in.row0_c   = ent[2];
      rsp_data_in.row1_a   = ent[3];
      rsp_data_in.row1_b   = ent[4];
      rsp_data_in.row1_c   = ent[5];
      rsp_data_in.row2_a   = ent[6];
      rsp_data_in.row2_b   = ent[7];
      rsp_data_in.row2_c   = ent[8];
      rsp_data_in.offset_x = shift_p4_ff[0];
      rsp_data_in.offset_y = shift_p4_ff[1];
      rsp_data_in.offset_z = shift_p4_ff[2];
   end

   // Datapath registers after the CORDIC lanes.
   always_ff @(posedge clock) begin
      if (adv) begin
         s_p0_ff     <= s_p0_in;
         c_p0_ff     <= c_p0_in;
         scale_p0_ff <= side_ln_ff[STEPS-1].scale;
         shift_p0_ff <= side_ln_ff[STEPS-1].shift;

         cycz_ff  <= mul_q30(c_p0_ff[1], c_p0_ff[2]);
         cysz_ff  <= mul_q30(c_p0_ff[1], s_p0_ff[2]);
         nsy_ff   <= -s_p0_ff[1];
         sxsy_ff  <= mul_q30(s_p0_ff[0], s_p0_ff[1]);
         cxsy_ff  <= mul_q30(c_p0_ff[0], s_p0_ff[1]);
         cxsz_ff  <= mul_q30(c_p0_ff[0], s_p0_ff[2]);
         cxcz_ff  <= mul_q30(c_p0_ff[0], c_p0_ff[2]);
         sxcy_ff  <= mul_q30(s_p0_ff[0], c_p0_ff[1]);
         sxsz_ff  <= mul_q30(s_p0_ff[0], s_p0_ff[2]);
         sxcz_ff  <= mul_q30(s_p0_ff[0], c_p0_ff[2]);
         cxcy_ff  <= mul_q30(c_p0_ff[0], c_p0_ff[1]);
         cz_ff    <= c_p0_ff[2];
         sz_ff    <= s_p0_ff[2];
         scale_p1_ff <= scale_p0_ff;
         shift_p1_ff <= shift_p0_ff;

         ta_ff    <= mul_q30(sxsy_ff, cz_ff);
         tb_ff    <= mul_q30(sxsy_ff, sz_ff);
         tc_ff    <= mul_q30(cxsy_ff, cz_ff);
         td_ff    <= mul_q30(cxsy_ff, sz_ff);
         m0_p2_ff <= cycz_ff;
         m1_p2_ff <= cysz_ff;
         m2_p2_ff <= nsy_ff;
         m5_p2_ff <= sxcy_ff;
         m8_p2_ff <= cxcy_ff;
         cxsz2_ff <= cxsz_ff;
         cxcz2_ff <= cxcz_ff;
         sxsz2_ff <= sxsz_ff;
         sxcz2_ff <= sxcz_ff;
         scale_p2_ff <= scale_p1_ff;
         shift_p2_ff <= shift_p1_ff;

         m_ff        <= m_in;
         scale_p3_ff <= scale_p2_ff;
         shift_p3_ff <= shift_p2_ff;

         prod_ff     <= prod_in;
         shift_p4_ff <= shift_p3_ff;

         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

[hdl/euler_srt_matrix_build.sv]
// Top level of the Euler scale-rotate-translate matrix builder.
// Depends on esmb_pkg, esmb_front, esmb_queue, esmb_back.
//
//   Channel   Direction  Ports                          Word
//   request   in         req_valid req_ready req_data   esmb_pkg::req_type
//   response  out        rsp_valid rsp_ready rsp_data   esmb_pkg::rsp_type
//
// One word enters and one leaves per cycle when neither side stalls.
// The path runs through two front stages, the queue, one radian stage, one stage per
// CORDIC iteration, five matrix stages and the output register.
// Reset is synchronous and clears only valid flags and the queue pointers and count.
// A response stall freezes the back end; the front can keep filling the queue meanwhile.
module euler_srt_matrix_build #(
   parameter int CORDIC_STEPS = esmb_pkg::CORDIC_STEPS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  esmb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output esmb_pkg::rsp_type rsp_data
);
   import esmb_pkg::*;

   logic     push_valid, push_ready, pop_valid, pop_ready;
   fold_type push_data, pop_data;

   // Angle reduction and folding.
   esmb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decoupling queue.
   esmb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Trigonometry and matrix arithmetic.
   esmb_back #(.STEPS(CORDIC_STEPS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
